/* hw/rtl/sida_pkg.sv */
package sida_pkg;

	// default slot count
	localparam int SLOTS_DEF = 64;

	// slots held in one memory row, and the bits that pick a slot in a row
	localparam int ROW_W = 16;
	localparam int ROW_BITS = 4;

	localparam logic [7:0] THRESHOLD_RESET = 8'd20;

	// request kinds
	localparam logic [1:0] REQ_ALLOC   = 2'd0;
	localparam logic [1:0] REQ_PIN     = 2'd1;
	localparam logic [1:0] REQ_COLLECT = 2'd2;
	localparam logic [1:0] REQ_MARK    = 2'd3;

	typedef struct packed {
		logic [1:0] req_type;
		logic [5:0] slot_id;
	} cmd_t;

	typedef struct packed {
		logic [5:0] granted_id;
		logic       granted;
		logic       collect_pending;
		logic [7:0] live_count;
		logic [5:0] last_position;
	} rsp_t;

	// one memory row: pinned bits above free bits
	typedef struct packed {
		logic [ROW_W-1:0] pinned;
		logic [ROW_W-1:0] free;
	} row_t;

endpackage

/* hw/rtl/slot_id_allocator_with_mark.sv */
// channel   | signals                        | transaction
// ----------+--------------------------------+---------------------------------------
// command   | start, busy, cmd               | start high while busy low
// response  | rsp_valid, rsp                 | one-cycle strobe, cannot be held off
// config    | cfg_valid, cfg_ready, cfg_data | cfg_valid and cfg_ready both high
//
// the free and pinned maps live in one synchronous memory, ROW_W slots per row;
// every request is a read-modify-write of rows, one row read per cycle.
// allocate reads rows from the row of the search position on until one holds a
// free slot; when no slot is free it reads every row and the first row again.
// pin and mark read and write back one row; start collection sweeps every row.
// after reset a clearing pass writes every row with busy high;
// configuration writes are taken at any time, cfg_ready is always high.
// the response strobe comes the cycle after the last row step, and a new
// command may be accepted in that same cycle.
module slot_id_allocator_with_mark #(
	parameter int SLOTS = sida_pkg::SLOTS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  sida_pkg::cmd_t  cmd,
	output logic            rsp_valid,
	output sida_pkg::rsp_t  rsp,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [7:0]      cfg_data
);

	localparam int RW    = sida_pkg::ROW_W;
	localparam int BW    = sida_pkg::ROW_BITS;
	localparam int ROWS  = (SLOTS + RW - 1) / RW;
	localparam int RAW   = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int SW    = RAW + BW;
	localparam int IDW   = $clog2(SLOTS);
	localparam int STW   = $clog2(ROWS + 1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_MODIFY,
		ST_SWEEP
	} state_t;

	state_t state_q;

	// row memory
	sida_pkg::row_t mem [ROWS];
	sida_pkg::row_t rd_data_s1;
	sida_pkg::row_t wr_data;
	logic           wr_en;
	logic [RAW-1:0] rd_addr;

	// row being looked at, and how many rows the scan has read
	logic [RAW-1:0] row_s1;
	logic [RAW-1:0] row_next;
	logic [STW-1:0] step_s1;

	// captured command
	logic [1:0]     req_s1;
	logic [SW-1:0]  id_s1;
	logic           id_ok_s1;

	// scalar state
	logic [IDW-1:0] ss_q;
	logic [IDW-1:0] roots_q;
	logic [IDW-1:0] roots_next;
	logic [7:0]     live_q;
	logic [7:0]     live_inc;
	logic [7:0]     pinned_q;
	logic [7:0]     pinned_inc;
	logic           flag_q;
	logic [7:0]     thr_q;

	// result register
	logic           rsp_valid_q;
	logic [5:0]     gid_q;
	logic           granted_q;

	logic [SW-1:0]  ss_ext;
	logic [SW-1:0]  id_ext;
	logic           id_ok;
	logic [RW-1:0]  valid_mask;
	logic [RW-1:0]  low_mask;
	logic [RW-1:0]  cand;
	logic           hit;
	logic [BW-1:0]  hit_bit;

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;

	assign rsp.granted_id      = gid_q;
	assign rsp.granted         = granted_q;
	assign rsp.collect_pending = flag_q;
	assign rsp.live_count      = live_q;
	assign rsp.last_position   = 6'(ss_q);

	assign row_next   = (row_s1 == RAW'(ROWS - 1)) ? '0 : row_s1 + 1'b1;
	assign ss_ext     = SW'(ss_q);
	assign id_ext     = SW'(cmd.slot_id);
	assign id_ok      = ({26'd0, cmd.slot_id} < 32'(SLOTS));
	assign live_inc   = (live_q == 8'hFF) ? live_q : live_q + 8'd1;
	assign pinned_inc = (pinned_q == 8'hFF) ? pinned_q : pinned_q + 8'd1;
	assign roots_next = (roots_q == IDW'(SLOTS - 1)) ? '0 : roots_q + 1'b1;

	// slots of the current row that exist; padding slots past the end stay taken
	always_comb begin
		for (int b = 0; b < RW; b++) begin
			valid_mask[b] = (32'({row_s1, BW'(b)}) < 32'(SLOTS));
		end
	end

	// first row of a scan starts at the search position, later rows are whole
	assign low_mask = (step_s1 == '0) ? ({RW{1'b1}} << ss_ext[BW-1:0]) : {RW{1'b1}};
	assign cand     = rd_data_s1.free & low_mask;

	// lowest free slot in the row
	always_comb begin
		hit     = 1'b0;
		hit_bit = '0;
		for (int b = RW - 1; b >= 0; b--) begin
			if (cand[b]) begin
				hit     = 1'b1;
				hit_bit = BW'(b);
			end
		end
	end

	// read address for the next cycle
	always_comb begin
		case (state_q)
			ST_IDLE: begin
				case (cmd.req_type)
					sida_pkg::REQ_ALLOC:   rd_addr = ss_ext[SW-1:BW];
					sida_pkg::REQ_COLLECT: rd_addr = '0;
					default:               rd_addr = id_ext[SW-1:BW];
				endcase
			end
			ST_CLEAR, ST_SCAN, ST_SWEEP: rd_addr = row_next;
			default:                     rd_addr = row_s1;
		endcase
	end

	// row write-back, always to row_s1
	always_comb begin
		wr_en   = 1'b0;
		wr_data = rd_data_s1;
		case (state_q)
			ST_CLEAR: begin
				wr_en          = 1'b1;
				wr_data.pinned = '0;
				wr_data.free   = valid_mask;
			end
			ST_SCAN: begin
				wr_en                 = hit;
				wr_data.free[hit_bit] = 1'b0;
			end
			ST_MODIFY: begin
				wr_en                         = id_ok_s1;
				wr_data.free[id_s1[BW-1:0]]   = 1'b0;
				if (req_s1 == sida_pkg::REQ_PIN) begin
					wr_data.pinned[id_s1[BW-1:0]] = 1'b1;
				end
			end
			ST_SWEEP: begin
				wr_en        = 1'b1;
				wr_data.free = ~rd_data_s1.pinned & valid_mask;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[row_s1] <= wr_data;
		end
		rd_data_s1 <= mem[rd_addr];
	end

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= sida_pkg::THRESHOLD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			thr_q <= cfg_data;
		end
	end

	// control and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			row_s1      <= '0;
			step_s1     <= '0;
			req_s1      <= sida_pkg::REQ_ALLOC;
			id_s1       <= '0;
			id_ok_s1    <= 1'b0;
			ss_q        <= '0;
			roots_q     <= '0;
			live_q      <= '0;
			pinned_q    <= '0;
			flag_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
			gid_q       <= '0;
			granted_q   <= 1'b0;
		end else begin
			row_s1      <= rd_addr;
			rsp_valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					if (row_s1 == RAW'(ROWS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					step_s1 <= '0;
					if (start) begin
						req_s1   <= cmd.req_type;
						id_s1    <= id_ext;
						id_ok_s1 <= id_ok;
						case (cmd.req_type)
							sida_pkg::REQ_ALLOC:   state_q <= ST_SCAN;
							sida_pkg::REQ_COLLECT: state_q <= ST_SWEEP;
							default:               state_q <= ST_MODIFY;
						endcase
					end
				end
				ST_SCAN: begin
					if (hit) begin
						ss_q        <= IDW'({row_s1, hit_bit});
						gid_q       <= 6'(IDW'({row_s1, hit_bit}));
						granted_q   <= 1'b1;
						live_q      <= live_inc;
						flag_q      <= flag_q | (live_q > thr_q);
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end else if (step_s1 == STW'(ROWS)) begin
						// out of memory: only the collect request may change
						gid_q       <= '0;
						granted_q   <= 1'b0;
						flag_q      <= flag_q | (live_q > thr_q);
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end else begin
						step_s1 <= step_s1 + 1'b1;
					end
				end
				ST_MODIFY: begin
					if (id_ok_s1) begin
						live_q <= live_inc;
						if (req_s1 == sida_pkg::REQ_PIN) begin
							pinned_q <= pinned_inc;
						end else begin
							roots_q <= roots_next;
							ss_q    <= roots_next;
						end
					end
					gid_q       <= '0;
					granted_q   <= 1'b0;
					rsp_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				ST_SWEEP: begin
					if (row_s1 == RAW'(ROWS - 1)) begin
						live_q      <= pinned_q;
						flag_q      <= 1'b0;
						roots_q     <= '0;
						ss_q        <= '0;
						gid_q       <= '0;
						granted_q   <= 1'b0;
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* tb/tb_slot_id_allocator_with_mark.sv */
`timescale 1ns / 1ps

module tb_slot_id_allocator_with_mark;

	localparam int NSLOTS = 64;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	sida_pkg::cmd_t cmd;
	logic rsp_valid;
	sida_pkg::rsp_t rsp;
	logic cfg_valid;
	logic cfg_ready;
	logic [7:0] cfg_data;

	slot_id_allocator_with_mark #(
		.SLOTS(NSLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.rsp_valid(rsp_valid),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// shadow copy of the slot map, updated at every accepted command
	logic [NSLOTS-1:0] free_slots;
	logic [NSLOTS-1:0] pinned_slots;
	logic [7:0] pins_held;
	logic [7:0] live_held;
	logic [7:0] thresh;
	logic [5:0] scan_from;
	logic [5:0] root_count;
	logic gc_wanted;

	// responses owed by the block, oldest first
	sida_pkg::rsp_t due_rsp[$];

	int mismatch_cnt = 0;
	int sent_cnt = 0;
	bit steady = 0;

	// checker scratch
	sida_pkg::rsp_t want;
	string bad;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// watchdog: far beyond the slowest legal run
	initial begin
		#4_000_000;
		$display("tb: failure");
		$finish;
	end

	function automatic logic [7:0] bump(input logic [7:0] v);
		return (v == 8'hff) ? v : v + 8'd1;
	endfunction

	task automatic reset_slot_map();
		free_slots = '1;
		pinned_slots = '0;
		pins_held = '0;
		live_held = '0;
		thresh = sida_pkg::THRESHOLD_RESET;
		scan_from = '0;
		root_count = '0;
		gc_wanted = 1'b0;
	endtask

	// applies one command to the shadow map and returns the response it owes
	function automatic sida_pkg::rsp_t predict_slot_map(input sida_pkg::cmd_t c);
		sida_pkg::rsp_t r;
		int k;
		int j;
		bit found;
		r = '0;
		found = 0;
		case (c.req_type)
			sida_pkg::REQ_ALLOC: begin
				// round-robin scan from the search position: the slot last handed out, the root count after a mark
				for (k = 0; k < NSLOTS && !found; k++) begin
					j = (scan_from + k) % NSLOTS;
					if (free_slots[j]) begin
						free_slots[j] = 1'b0;
						scan_from = j[5:0];
						r.granted_id = j[5:0];
						r.granted = 1'b1;
						found = 1;
					end
				end
				// the request flag looks at the count before this grant,
				// and is raised even when the map is full
				if (live_held > thresh)
					gc_wanted = 1'b1;
				if (found)
					live_held = bump(live_held);
			end
			sida_pkg::REQ_PIN: begin
				// pinning again counts again
				free_slots[c.slot_id] = 1'b0;
				pinned_slots[c.slot_id] = 1'b1;
				pins_held = bump(pins_held);
				live_held = bump(live_held);
			end
			sida_pkg::REQ_COLLECT: begin
				free_slots = ~pinned_slots;
				live_held = pins_held;
				gc_wanted = 1'b0;
				root_count = '0;
				scan_from = '0;
			end
			default: begin
				// mark root: the 6-bit root count wraps at the slot count
				free_slots[c.slot_id] = 1'b0;
				live_held = bump(live_held);
				root_count = root_count + 6'd1;
				scan_from = root_count;
			end
		endcase
		r.collect_pending = gc_wanted;
		r.live_count = live_held;
		r.last_position = scan_from;
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	task automatic note_failure(input string msg);
		mismatch_cnt++;
		if (mismatch_cnt <= 10)
			$display("ERROR: %s", msg);
	endtask

	// one command transaction; entered and left on a falling edge
	task automatic send_cmd(input logic [1:0] kind, input logic [5:0] id);
		sida_pkg::cmd_t c;
		sida_pkg::rsp_t owed;
		int gap;
		c.req_type = kind;
		c.slot_id = id;
		cmd = c;
		start = 1'b1;
		do
			@(posedge clk);
		while (busy);
		owed = predict_slot_map(c);
		due_rsp = {due_rsp, owed};
		sent_cnt++;
		@(negedge clk);
		// a following send_cmd raises start again in this same step
		start = 1'b0;
		gap = pick_gap();
		repeat (gap) @(negedge clk);
	endtask

	// threshold write, only once every owed response is back
	task automatic write_threshold(input logic [7:0] v);
		while (due_rsp.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
		cfg_data = v;
		cfg_valid = 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		thresh = v;
		@(negedge clk);
		cfg_valid = 1'b0;
		cfg_data = 8'($urandom_range(0, 255));
	endtask

	// response checker: every strobe must match the oldest owed response
	always @(posedge clk) begin
		if (arst_n && rsp_valid) begin
			if (due_rsp.size() == 0) begin
				note_failure($sformatf(
					"response with none owed: id=%0d g=%0b cp=%0b live=%0d pos=%0d",
					rsp.granted_id, rsp.granted, rsp.collect_pending, rsp.live_count,
					rsp.last_position));
			end else begin
				want = due_rsp.pop_front();
				bad = "";
				if (rsp.granted_id !== want.granted_id)
					bad = {bad, " granted_id"};
				if (rsp.granted !== want.granted)
					bad = {bad, " granted"};
				if (rsp.collect_pending !== want.collect_pending)
					bad = {bad, " collect_pending"};
				if (rsp.live_count !== want.live_count)
					bad = {bad, " live_count"};
				if (rsp.last_position !== want.last_position)
					bad = {bad, " last_position"};
				if (bad != "")
					note_failure({
						$sformatf("%s wrong: want id=%0d g=%0b cp=%0b live=%0d pos=%0d",
							bad, want.granted_id, want.granted, want.collect_pending,
							want.live_count, want.last_position),
						$sformatf(", got id=%0d g=%0b cp=%0b live=%0d pos=%0d",
							rsp.granted_id, rsp.granted, rsp.collect_pending,
							rsp.live_count, rsp.last_position)});
			end
		end
	end

	// short hand-picked sequence: every request kind, id extremes, repeats
	task automatic test_directed();
		write_threshold(8'd0);
		send_cmd(sida_pkg::REQ_ALLOC, 6'h00);
		send_cmd(sida_pkg::REQ_ALLOC, 6'h3f);     // count now 1 > 0, flag goes up
		send_cmd(sida_pkg::REQ_PIN, 6'h00);       // pin a slot already taken
		send_cmd(sida_pkg::REQ_PIN, 6'h3f);
		send_cmd(sida_pkg::REQ_PIN, 6'h3f);       // pin twice, counts twice
		send_cmd(sida_pkg::REQ_MARK, 6'h3f);
		send_cmd(sida_pkg::REQ_MARK, 6'h2a);
		send_cmd(sida_pkg::REQ_MARK, 6'h15);
		send_cmd(sida_pkg::REQ_ALLOC, 6'h2a);     // scan starts at the root count
		send_cmd(sida_pkg::REQ_COLLECT, 6'h15);
		send_cmd(sida_pkg::REQ_ALLOC, 6'h00);     // slot 0 pinned, skipped
		send_cmd(sida_pkg::REQ_MARK, 6'h00);
		send_cmd(sida_pkg::REQ_MARK, 6'h00);      // mark twice
		send_cmd(sida_pkg::REQ_ALLOC, 6'h3f);
		send_cmd(sida_pkg::REQ_ALLOC, 6'h00);
		send_cmd(sida_pkg::REQ_COLLECT, 6'h3f);
		send_cmd(sida_pkg::REQ_COLLECT, 6'h00);   // back to back collections
	endtask

	// run the map dry: the flag rises partway through, and the last allocations are refused
	task automatic test_fill();
		write_threshold(8'd40);
		send_cmd(sida_pkg::REQ_COLLECT, 6'($urandom_range(0, 63)));
		repeat (NSLOTS + 4)
			send_cmd(sida_pkg::REQ_ALLOC, 6'($urandom_range(0, 63)));
		send_cmd(sida_pkg::REQ_COLLECT, 6'($urandom_range(0, 63)));
	endtask

	// mostly collect / mark / allocate cycles with random content, plus noise;
	// pins stay rare since nothing ever unpins a slot
	task automatic test_random();
		logic [7:0] levels[8];
		int goal;
		int r;
		int n;
		logic [1:0] kind;
		levels = '{8'd255, 8'd0, 8'd5, 8'd12, 8'd30, 8'd255, 8'd0, 8'd60};
		for (int p = 0; p < 8; p++) begin
			if (p >= 2 && $urandom_range(0, 2) == 0)
				write_threshold(8'($urandom_range(0, 255)));
			else
				write_threshold(levels[p]);
			steady = ($urandom_range(0, 3) == 0);
			goal = sent_cnt + 120;
			while (sent_cnt < goal) begin
				r = $urandom_range(0, 99);
				if (r < 40) begin
					// a full mark phase followed by fresh allocations
					send_cmd(sida_pkg::REQ_COLLECT, 6'($urandom_range(0, 63)));
					n = $urandom_range(0, 8);
					repeat (n) send_cmd(sida_pkg::REQ_MARK, 6'($urandom_range(0, 63)));
					n = $urandom_range(1, 70);
					repeat (n) send_cmd(sida_pkg::REQ_ALLOC, 6'($urandom_range(0, 63)));
				end else if (r < 65) begin
					n = $urandom_range(1, 80);
					repeat (n) send_cmd(sida_pkg::REQ_ALLOC, 6'($urandom_range(0, 63)));
				end else if (r < 75) begin
					n = $urandom_range(1, 12);
					repeat (n) send_cmd(sida_pkg::REQ_MARK, 6'($urandom_range(0, 63)));
				end else if (r < 77) begin
					send_cmd(sida_pkg::REQ_PIN, 6'($urandom_range(0, 63)));
				end else begin
					kind = 2'($urandom_range(0, 3));
					if (kind == sida_pkg::REQ_PIN && $urandom_range(0, 3) != 0)
						kind = sida_pkg::REQ_MARK;
					send_cmd(kind, 6'($urandom_range(0, 63)));
				end
			end
		end
		steady = 0;
	endtask

	// counters at saturation, root count wrapping, every slot pinned
	task automatic test_saturation();
		write_threshold(8'd100);
		send_cmd(sida_pkg::REQ_COLLECT, 6'h00);
		// enough marks to wrap the root count
		repeat (200) send_cmd(sida_pkg::REQ_MARK, 6'($urandom_range(0, 63)));
		for (int k = 0; k < 260; k++)
			send_cmd(sida_pkg::REQ_PIN, 6'(k % NSLOTS));
		send_cmd(sida_pkg::REQ_COLLECT, 6'h3f);
		// nothing free: refused, and 255 is above 100
		repeat (4) send_cmd(sida_pkg::REQ_ALLOC, 6'($urandom_range(0, 63)));
		write_threshold(8'd255);
		send_cmd(sida_pkg::REQ_COLLECT, 6'h00);
		// 255 is not above 255: refused with no flag
		repeat (3) send_cmd(sida_pkg::REQ_ALLOC, 6'($urandom_range(0, 63)));
		send_cmd(sida_pkg::REQ_MARK, 6'h3f);
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		reset_slot_map();
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_fill();
		test_random();
		test_saturation();

		// drain, then keep watching for any stray strobe
		while (due_rsp.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (due_rsp.size() != 0)
			note_failure($sformatf("%0d responses never arrived", due_rsp.size()));

		if (mismatch_cnt == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
